### hdl/sctil_pkg.sv
package sctil_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] KIND_STEP   = 3'd0;
  localparam logic [2:0] KIND_LINEAR = 3'd1;
  localparam logic [2:0] KIND_ADD    = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_FIND   = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_BAD_POS = 2'd2;

  localparam logic [7:0] INDEX_NONE = 8'hFF;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_cmp;
    logic decide;
    logic div_step;
    logic mul;
    logic add;
    logic ins_rd;
    logic ins_wr;
    logic rm_init;
    logic rm_bad;
    logic rm_rd;
    logic rm_wr;
    logic clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       scan_end;
    logic       hit;
    logic       need_div;
    logic       add_replace;
    logic       full;
    logic       pos_bad;
    logic       div_end;
    logic       ins_end;
    logic       rm_end;
    logic       out_free;
  } sts_t;

endpackage

### hdl/sctil_ram.sv
module sctil_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/sctil_ctrl.sv
module sctil_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sctil_pkg::sts_t     sts_i,
  output sctil_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISP     = 4'd1;
  localparam logic [3:0] ST_SCAN_RD  = 4'd2;
  localparam logic [3:0] ST_SCAN_CMP = 4'd3;
  localparam logic [3:0] ST_DECIDE   = 4'd4;
  localparam logic [3:0] ST_DIV      = 4'd5;
  localparam logic [3:0] ST_MUL      = 4'd6;
  localparam logic [3:0] ST_ADD      = 4'd7;
  localparam logic [3:0] ST_INS_RD   = 4'd8;
  localparam logic [3:0] ST_INS_WR   = 4'd9;
  localparam logic [3:0] ST_RM_RD    = 4'd10;
  localparam logic [3:0] ST_RM_WR    = 4'd11;
  localparam logic [3:0] ST_DONE     = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.kind)
          sctil_pkg::KIND_STEP, sctil_pkg::KIND_LINEAR,
          sctil_pkg::KIND_ADD, sctil_pkg::KIND_FIND: begin
            state_d = ST_SCAN_RD;
          end
          sctil_pkg::KIND_REMOVE: begin
            if (sts_i.pos_bad) begin
              cmd_o.rm_bad = 1'b1;
              state_d      = ST_DONE;
            end else begin
              cmd_o.rm_init = 1'b1;
              state_d       = ST_RM_RD;
            end
          end
          sctil_pkg::KIND_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_end) begin
          state_d = ST_DECIDE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = sts_i.hit ? ST_DECIDE : ST_SCAN_RD;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_DONE;
        if (sts_i.kind == sctil_pkg::KIND_LINEAR && sts_i.need_div) begin
          state_d = ST_DIV;
        end else if (sts_i.kind == sctil_pkg::KIND_ADD && !sts_i.add_replace &&
                     !sts_i.full) begin
          state_d = ST_INS_RD;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = sts_i.div_end ? ST_MUL : ST_DIV;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_DONE;
      end
      ST_INS_RD: begin
        cmd_o.ins_rd = 1'b1;
        state_d      = sts_i.ins_end ? ST_DONE : ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = ST_INS_RD;
      end
      ST_RM_RD: begin
        cmd_o.rm_rd = 1'b1;
        state_d     = sts_i.rm_end ? ST_DONE : ST_RM_WR;
      end
      ST_RM_WR: begin
        cmd_o.rm_wr = 1'b1;
        state_d     = ST_RM_RD;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/sctil_dpath.sv
module sctil_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sctil_pkg::cmd_t     cmd_i,
  output sctil_pkg::sts_t     sts_o,
  input  logic [2:0]          kind_i,
  input  logic signed [31:0]  coord_i,
  input  logic signed [31:0]  value_i,
  input  logic [30:0]         tolerance_i,
  input  logic [5:0]          position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  result_value_o,
  output logic signed [7:0]   result_index_o,
  output logic [1:0]          status_o
);

  localparam int unsigned IW = sctil_pkg::IDX_W;
  localparam int unsigned CW = sctil_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(sctil_pkg::MAX_POINTS);

  logic [2:0]         kind_q;
  logic signed [31:0] coord_q, value_q;
  logic [30:0]        tol_q;
  logic [5:0]         pos_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      p_q, j_q;
  logic signed [31:0] px_q, py_q, nx_q, ny_q;
  logic               found_q, match_q;
  logic [31:0]        rem_q, den_q;
  logic [15:0]        b_q;
  logic [3:0]         dc_q;
  logic signed [49:0] prod_q;
  logic signed [31:0] rv_q;
  logic [7:0]         ri_q;
  logic [1:0]         st_q;
  logic               ov_q;

  logic               we;
  logic [IW-1:0]      waddr, raddr;
  logic [63:0]        wdata, rdata;
  logic signed [31:0] rx, ry;

  assign rx = rdata[63:32];
  assign ry = rdata[31:0];

  sctil_ram #(.WIDTH(64), .DEPTH(sctil_pkg::MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic signed [33:0] lower, upper, rx34;
  logic               less, above, hit;
  logic signed [32:0] diff;
  logic               replace;
  logic [32:0]        trial;
  logic signed [32:0] dy;
  logic [CW-1:0]      p_inc;

  assign p_inc = p_q + CW'(1);
  assign lower = 34'(coord_q) - 34'($signed({1'b0, tol_q}));
  assign upper = 34'(coord_q) + 34'($signed({1'b0, tol_q}));
  assign rx34  = 34'(rx);
  assign less  = coord_q < rx;
  assign above = rx34 > upper;
  assign hit   = (kind_q == sctil_pkg::KIND_FIND) ? (above || rx34 >= lower) : less;
  assign diff  = 33'(coord_q) - 33'(px_q);
  assign replace = (p_q != '0) && (diff <= $signed({2'b00, tol_q}));
  assign trial = {rem_q, 1'b0};
  assign dy    = 33'(ny_q) - 33'(py_q);

  always_comb begin
    sts_o.kind        = kind_q;
    sts_o.scan_end    = (p_q == cnt_q);
    sts_o.hit         = hit;
    sts_o.need_div    = found_q && (p_q != '0);
    sts_o.add_replace = replace;
    sts_o.full        = (cnt_q >= CNT_MAX);
    sts_o.pos_bad     = (CW'(pos_q) >= cnt_q);
    sts_o.div_end     = (dc_q == 4'd15);
    sts_o.ins_end     = (j_q == p_q);
    sts_o.rm_end      = (p_inc >= cnt_q);
    sts_o.out_free    = !ov_q || out_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    waddr = p_q[IW-1:0];
    wdata = rdata;
    raddr = p_q[IW-1:0];
    if (cmd_i.scan_rd) begin
      raddr = p_q[IW-1:0];
    end else if (cmd_i.ins_rd) begin
      raddr = IW'(j_q - CW'(1));
    end else if (cmd_i.rm_rd) begin
      raddr = p_inc[IW-1:0];
    end
    if (cmd_i.decide && kind_q == sctil_pkg::KIND_ADD && replace) begin
      we    = 1'b1;
      waddr = IW'(p_q - CW'(1));
      wdata = {px_q, value_q};
    end else if (cmd_i.ins_rd && j_q == p_q) begin
      we    = 1'b1;
      wdata = {coord_q, value_q};
    end else if (cmd_i.ins_wr) begin
      we    = 1'b1;
      waddr = j_q[IW-1:0];
    end else if (cmd_i.rm_wr) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (cmd_i.ins_rd && j_q == p_q) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.rm_rd && p_inc >= cnt_q) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      coord_q <= coord_i;
      value_q <= value_i;
      tol_q   <= tolerance_i;
      pos_q   <= position_i;
      p_q     <= '0;
      found_q <= 1'b0;
      match_q <= 1'b0;
      rv_q    <= '0;
      ri_q    <= sctil_pkg::INDEX_NONE;
      st_q    <= sctil_pkg::STATUS_OK;
    end
    if (cmd_i.scan_cmp) begin
      if (hit) begin
        nx_q    <= rx;
        ny_q    <= ry;
        found_q <= 1'b1;
        match_q <= !above;
      end else begin
        px_q <= rx;
        py_q <= ry;
        p_q  <= p_inc;
      end
    end
    if (cmd_i.decide) begin
      unique case (kind_q)
        sctil_pkg::KIND_STEP, sctil_pkg::KIND_LINEAR: begin
          if (cnt_q == '0) begin
            rv_q <= '0;
          end else if (found_q && p_q == '0) begin
            rv_q <= ny_q;
          end else begin
            rv_q <= py_q;
          end
          rem_q <= 32'(diff);
          den_q <= nx_q - px_q;
          b_q   <= '0;
          dc_q  <= '0;
        end
        sctil_pkg::KIND_ADD: begin
          if (replace) begin
            ri_q <= 8'(p_q - CW'(1));
          end else if (cnt_q >= CNT_MAX) begin
            st_q <= sctil_pkg::STATUS_FULL;
          end
          j_q <= cnt_q;
        end
        sctil_pkg::KIND_FIND: begin
          if (found_q && match_q) begin
            ri_q <= 8'(p_q);
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.div_step) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= 32'(trial - {1'b0, den_q});
        b_q   <= {b_q[14:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        b_q   <= {b_q[14:0], 1'b0};
      end
      dc_q <= dc_q + 4'd1;
    end
    if (cmd_i.mul) begin
      prod_q <= 50'(dy * $signed({1'b0, b_q}));
    end
    if (cmd_i.add) begin
      rv_q <= py_q + 32'(prod_q >>> 16);
    end
    if (cmd_i.ins_rd && j_q == p_q) begin
      ri_q <= 8'(p_q);
    end
    if (cmd_i.ins_wr) begin
      j_q <= j_q - CW'(1);
    end
    if (cmd_i.rm_init) begin
      p_q  <= CW'(pos_q);
      ri_q <= 8'(pos_q);
    end
    if (cmd_i.rm_bad) begin
      st_q <= sctil_pkg::STATUS_BAD_POS;
    end
    if (cmd_i.rm_wr) begin
      p_q <= p_inc;
    end
    if (cmd_i.out_load) begin
      result_value_o <= rv_q;
      result_index_o <= ri_q;
      status_o       <= st_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule

### hdl/sorted_curve_table_interpolator.sv
// Sorted curve table with step and linear interpolation lookup.
// The input channel (in_valid_i/in_ready_o) takes one operation per beat:
// evaluate as a step function, evaluate linearly, add, remove, find or clear.
// The output channel (out_valid_o/out_ready_i) returns one beat per operation
// with the evaluated value, the index written or found, and a status code.
// The block works on one operation at a time. A lookup scans the points from
// the start, one point at a time, through the single read port of the point
// memory. Linear interpolation adds a serial divide to a 16-bit quotient and
// then a multiply and an add. Insert and remove shift the entries behind the
// position one entry at a time, in a table of at most 64 points.
// The result sits in an output register; while the receiver stalls the next
// operation is still accepted and runs up to its result, then waits there.
// Reset empties the table at once; the point memory itself is not cleared.
module sorted_curve_table_interpolator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] coord_i,
  input  logic signed [31:0] value_i,
  input  logic [30:0]        tolerance_i,
  input  logic [5:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic signed [7:0]  result_index_o,
  output logic [1:0]         status_o
);

  sctil_pkg::cmd_t cmd;
  sctil_pkg::sts_t sts;

  sctil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sctil_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .coord_i        (coord_i),
    .value_i        (value_i),
    .tolerance_i    (tolerance_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .result_index_o (result_index_o),
    .status_o       (status_o)
  );

endmodule
